// ===== hdl/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg
// Shared constants, operation codes and controller states for the
// double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int FUNC_WIDTH         = 3;

   // operation codes carried in the func field of a request word
   typedef enum logic [FUNC_WIDTH-1:0] {
      FUNC_PUSH_FRONT = 3'd0,
      FUNC_PUSH_BACK  = 3'd1,
      FUNC_POP_FRONT  = 3'd2,
      FUNC_POP_BACK   = 3'd3,
      FUNC_WALK       = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_WALK
   } state_type;

endpackage

// ===== hdl/dq_channels.sv =====
// ----------------------------------------------------------------------------
// dq_channels
// Valid/ready channel interfaces for the request and response words of the
// double-ended queue.
// ----------------------------------------------------------------------------
interface dq_req_if
   import dq_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) ();
   logic                         valid;
   logic                         ready;
   logic [FUNC_WIDTH-1:0]        func;
   logic signed [DATA_WIDTH-1:0] value;

   modport source (output valid, output func, output value, input ready);
   modport sink   (input valid, input func, input value, output ready);
endinterface

interface dq_rsp_if
   import dq_pkg::*;
#(
   parameter int DATA_WIDTH  = DATA_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH = $clog2(DEPTH_DEFAULT + 1)
) ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] value_res;
   logic                         last;
   logic                         empty_res;
   logic [COUNT_WIDTH-1:0]       count;
   logic                         refused;

   modport source (output valid, output value_res, output last, output empty_res,
                   output count, output refused, input ready);
   modport sink   (input valid, input value_res, input last, input empty_res,
                   input count, input refused, output ready);
endinterface

// ===== hdl/dq_ram.sv =====
// ----------------------------------------------------------------------------
// dq_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data until the next read.
// ----------------------------------------------------------------------------
module dq_ram
   import dq_pkg::*;
#(
   parameter int WIDTH = DATA_WIDTH_DEFAULT,
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/double_ended_queue_top.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue of signed words kept as a ring in one RAM,
// tracked by a head index and an entry count.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------------------
//  req_ch   | in  | valid / ready | func, value
//  rsp_ch   | out | valid / ready | value_res, last, empty_res, count, refused
//
//  a push, a refused push, an empty pop or an unknown func is answered straight from idle
//  a pop that finds data answers from the pop state, after the registered ring RAM read
//  a walk does one RAM read per stored word; an empty walk answers with nothing
//  reset clears state, head, count, walk index and response valid; ring contents are never cleared
//  a new request is taken in the same cycle the last word leaves the
//  response register; a stalled response holds the controller until it is taken
// ----------------------------------------------------------------------------
module double_ended_queue_top
   import dq_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   dq_req_if.sink   req_ch,
   dq_rsp_if.source rsp_ch
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W:0]   DEPTH_WIDE = (IDX_W + 1)'(DEPTH);
   localparam logic [IDX_W-1:0] DEPTH_DEC  = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   // modular add on the ring, both operands below DEPTH
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] offs);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, offs};
      if (sum >= DEPTH_WIDE) begin
         sum = sum - DEPTH_WIDE;
      end
      return sum[IDX_W-1:0];
   endfunction

   state_type state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] walk_ff, walk_in;

   logic                         out_valid_ff, out_valid_in;
   logic signed [DATA_WIDTH-1:0] out_value_ff, out_value_in;
   logic                         out_last_ff, out_last_in;
   logic                         out_empty_ff, out_empty_in;
   logic [CNT_W-1:0]             out_count_ff, out_count_in;
   logic                         out_refused_ff, out_refused_in;

   logic                  ram_we, ram_re;
   logic [IDX_W-1:0]      ram_waddr, ram_raddr;
   logic [DATA_WIDTH-1:0] ram_rdata;

   logic             slot_free;
   logic             req_take;
   logic             no_entries, is_full;
   logic [CNT_W-1:0] count_dec;
   logic [CNT_W-1:0] walk_next;
   logic             walk_last;
   func_type         func;

   logic                         out_load;
   logic signed [DATA_WIDTH-1:0] ld_value;
   logic                         ld_last;
   logic                         ld_refused;

   assign func       = func_type'(req_ch.func);
   assign slot_free  = !out_valid_ff || rsp_ch.ready;
   assign req_take   = (state_ff == ST_IDLE) && req_ch.valid && slot_free;
   assign no_entries = (count_ff == '0);
   assign is_full    = (count_ff == FULL_COUNT);
   assign count_dec  = count_ff - CNT_W'(1);
   assign walk_next  = walk_ff + CNT_W'(1);
   assign walk_last  = (walk_next == count_ff);

   dq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_ch.value),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && !no_entries) begin
               if (func == FUNC_POP_FRONT || func == FUNC_POP_BACK) begin
                  state_in = ST_POP;
               end else if (func == FUNC_WALK) begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_POP: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_WALK: begin
            if (slot_free && walk_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and ring control
   always_comb begin
      req_ch.ready = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_waddr    = head_ff;
      ram_raddr    = head_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      walk_in      = walk_ff;
      out_load     = 1'b0;
      ld_value     = '0;
      ld_last      = 1'b1;
      ld_refused   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = slot_free;
            if (req_take) begin
               unique case (func)
                  FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
                     out_load = 1'b1;
                     if (is_full) begin
                        ld_refused = 1'b1;
                     end else begin
                        ram_we   = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        if (func == FUNC_PUSH_FRONT) begin
                           head_in   = ring_add(head_ff, DEPTH_DEC);
                           ram_waddr = head_in;
                        end else begin
                           ram_waddr = ring_add(head_ff, count_ff[IDX_W-1:0]);
                        end
                     end
                  end
                  FUNC_POP_FRONT: begin
                     if (no_entries) begin
                        out_load = 1'b1;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = head_ff;
                        head_in   = ring_add(head_ff, IDX_W'(1));
                        count_in  = count_dec;
                     end
                  end
                  FUNC_POP_BACK: begin
                     if (no_entries) begin
                        out_load = 1'b1;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = ring_add(head_ff, count_dec[IDX_W-1:0]);
                        count_in  = count_dec;
                     end
                  end
                  FUNC_WALK: begin
                     // an empty walk answers with nothing
                     if (!no_entries) begin
                        ram_re    = 1'b1;
                        ram_raddr = head_ff;
                        walk_in   = '0;
                     end
                  end
                  default: begin
                     out_load = 1'b1;
                  end
               endcase
            end
         end
         ST_POP: begin
            if (slot_free) begin
               out_load = 1'b1;
               ld_value = ram_rdata;
            end
         end
         ST_WALK: begin
            if (slot_free) begin
               out_load = 1'b1;
               ld_value = ram_rdata;
               ld_last  = walk_last;
               if (!walk_last) begin
                  // fetch the next word while this one goes out
                  walk_in   = walk_next;
                  ram_re    = 1'b1;
                  ram_raddr = ring_add(head_ff, walk_next[IDX_W-1:0]);
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign out_valid_in   = out_load || (out_valid_ff && !rsp_ch.ready);
   assign out_value_in   = out_load ? ld_value : out_value_ff;
   assign out_last_in    = out_load ? ld_last : out_last_ff;
   assign out_empty_in   = out_load ? (count_in == '0) : out_empty_ff;
   assign out_count_in   = out_load ? count_in : out_count_ff;
   assign out_refused_in = out_load ? ld_refused : out_refused_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         walk_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         walk_ff      <= walk_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff   <= out_value_in;
      out_last_ff    <= out_last_in;
      out_empty_ff   <= out_empty_in;
      out_count_ff   <= out_count_in;
      out_refused_ff <= out_refused_in;
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.value_res = out_value_ff;
   assign rsp_ch.last      = out_last_ff;
   assign rsp_ch.empty_res = out_empty_ff;
   assign rsp_ch.count     = out_count_ff;
   assign rsp_ch.refused   = out_refused_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above depth");

   a_refused_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.refused) |-> (rsp_ch.count == FULL_COUNT))
      else $error("refused push with free room");

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> (state_ff == ST_IDLE))
      else $error("request taken while busy");

   a_pop_no_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |-> !ram_re)
      else $error("ring read would overwrite pop data");

   a_walk_keeps_ring: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (!ram_we && $stable(count_ff)))
      else $error("ring changed during walk");

endmodule
